// ===== rtl/core/rcms_pkg.sv =====
// Package for the RC mode switch decoder: shared types, codes and thresholds.
// No dependencies.
`timescale 1ns / 1ps

package rcms_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 48;
    localparam int unsigned PulseWidth    = 16;
    localparam int unsigned PosWidth      = 4;
    localparam int unsigned ModeWidth     = 8;
    localparam int unsigned PosCount      = 12;

    localparam logic [PulseWidth-1:0] PulseMin = 16'd900;
    localparam logic [PulseWidth-1:0] PulseMax = 16'd2200;

    localparam logic [PosWidth-1:0] PosOutOfRange = 4'd12;
    localparam logic [PosWidth-1:0] PosNone       = 4'd15;

    localparam logic [PulseWidth-1:0] SixLimits [5] = '{
        16'd1231, 16'd1361, 16'd1491, 16'd1621, 16'd1750
    };
    localparam logic [PulseWidth-1:0] TwelveLimits [11] = '{
        16'd1126, 16'd1201, 16'd1276, 16'd1351, 16'd1426, 16'd1501,
        16'd1576, 16'd1651, 16'd1726, 16'd1801, 16'd1876
    };

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_EXTENDED_MODE   = 3'd0,
        CFG_MODE_TABLE_LOW  = 3'd1,
        CFG_MODE_TABLE_HIGH = 3'd2,
        CFG_SIMPLE_MASK     = 3'd3,
        CFG_SUPER_MASK      = 3'd4,
        CFG_AUX_SIMPLE      = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        SIMPLE_NONE  = 2'd0,
        SIMPLE_ON    = 2'd1,
        SIMPLE_SUPER = 2'd2
    } simple_setting_t;

    typedef struct packed {
        logic                    extended_mode;
        logic [CfgDataWidth-1:0] mode_table_low;
        logic [CfgDataWidth-1:0] mode_table_high;
        logic [PosCount-1:0]     simple_mask;
        logic [PosCount-1:0]     super_simple_mask;
        logic                    aux_simple_assigned;
    } cfg_t;

    typedef struct packed {
        logic                  action;
        logic [PulseWidth-1:0] pulse_width;
        logic                  radio_valid;
        logic                  mode_accepted;
    } item_t;

    typedef struct packed {
        logic [PosWidth-1:0]  position;
        logic                 mode_request;
        logic [ModeWidth-1:0] mode_number;
        logic                 simple_update;
        simple_setting_t      simple_setting;
    } result_t;

endpackage

// ===== rtl/core/rcms_pulse_decode.sv =====
// Pulse width to switch position decode by fixed thresholds.
// Depends on rcms_pkg.
`timescale 1ns / 1ps

module rcms_pulse_decode (
    input  logic [rcms_pkg::PulseWidth-1:0] pulse_width,
    input  logic                            extended_mode,
    output logic [rcms_pkg::PosWidth-1:0]   position
);

    always_comb begin
        logic [rcms_pkg::PosWidth-1:0] cnt;
        cnt = '0;
        if (extended_mode) begin
            for (int i = 0; i < 11; i++) begin
                cnt = cnt + rcms_pkg::PosWidth'(pulse_width >= rcms_pkg::TwelveLimits[i]);
            end
        end else begin
            for (int i = 0; i < 5; i++) begin
                cnt = cnt + rcms_pkg::PosWidth'(pulse_width >= rcms_pkg::SixLimits[i]);
            end
        end
        if (pulse_width <= rcms_pkg::PulseMin || pulse_width >= rcms_pkg::PulseMax) begin
            position = rcms_pkg::PosOutOfRange;
        end else begin
            position = cnt;
        end
    end

endmodule

// ===== rtl/core/rcms_switch_ctrl.sv =====
// Debounce state, mode table lookup and simple-mode selection.
// Depends on rcms_pkg and rcms_pulse_decode.
`timescale 1ns / 1ps

module rcms_switch_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  rcms_pkg::item_t   item,
    input  rcms_pkg::cfg_t    cfg,
    output rcms_pkg::result_t result
);

    logic [rcms_pkg::PosWidth-1:0] stored_reg, stored_next;
    logic                          pending_reg, pending_next;
    logic [rcms_pkg::PosWidth-1:0] pos;

    rcms_pulse_decode u_decode (
        .pulse_width   (item.pulse_width),
        .extended_mode (cfg.extended_mode),
        .position      (pos)
    );

    always_comb begin
        logic [rcms_pkg::PosWidth-1:0] cur;
        logic [2*rcms_pkg::CfgDataWidth-1:0] tbl;
        cur          = item.action ? rcms_pkg::PosNone : stored_reg;
        tbl          = {cfg.mode_table_high, cfg.mode_table_low};
        stored_next  = cur;
        pending_next = pending_reg;
        result                = '0;
        result.position       = pos;
        result.simple_setting = rcms_pkg::SIMPLE_NONE;
        if (pos != rcms_pkg::PosOutOfRange && item.radio_valid) begin
            if (cur != pos) begin
                if (!pending_reg) begin
                    pending_next = 1'b1;
                end else begin
                    result.mode_request = 1'b1;
                    result.mode_number  = tbl[{pos, 3'b000} +: rcms_pkg::ModeWidth];
                    stored_next         = pos;
                    if (item.mode_accepted) begin
                        pending_next = 1'b0;
                        if (!cfg.aux_simple_assigned) begin
                            result.simple_update = 1'b1;
                            if (cfg.super_simple_mask[pos]) begin
                                result.simple_setting = rcms_pkg::SIMPLE_SUPER;
                            end else if (cfg.simple_mask[pos]) begin
                                result.simple_setting = rcms_pkg::SIMPLE_ON;
                            end
                        end
                    end
                end
            end else begin
                pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_reg  <= rcms_pkg::PosNone;
            pending_reg <= 1'b0;
        end else if (advance) begin
            stored_reg  <= stored_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ===== rtl/core/rc_mode_switch_decoder.sv =====
// Top level of the RC mode switch decoder: config registers, input and result registers.
// Depends on rcms_pkg and rcms_switch_ctrl.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while m_ready is held high; the result register frees as it is taken.
// Reset (aresetn, synchronous, active low): configuration cleared, stored position none,
// no change pending, both pipeline stages empty.
`timescale 1ns / 1ps

module rc_mode_switch_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rcms_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [rcms_pkg::CfgDataWidth-1:0]  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [rcms_pkg::PulseWidth-1:0]   s_pulse_width,
    input  logic                              s_radio_valid,
    input  logic                              s_mode_accepted,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rcms_pkg::PosWidth-1:0]     m_position,
    output logic                              m_mode_request,
    output logic [rcms_pkg::ModeWidth-1:0]    m_mode_number,
    output logic                              m_simple_update,
    output logic [1:0]                        m_simple_setting
);

    rcms_pkg::cfg_t    cfg_reg;
    rcms_pkg::item_t   item_reg;
    logic              item_valid_reg;
    rcms_pkg::result_t result_reg, result_next;
    logic              m_valid_reg;
    logic              advance;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = item_valid_reg && out_free;
    assign s_ready  = !item_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (rcms_pkg::cfg_index_t'(cfg_index))
                rcms_pkg::CFG_EXTENDED_MODE:   cfg_reg.extended_mode <= cfg_wdata[0];
                rcms_pkg::CFG_MODE_TABLE_LOW:  cfg_reg.mode_table_low <= cfg_wdata;
                rcms_pkg::CFG_MODE_TABLE_HIGH: cfg_reg.mode_table_high <= cfg_wdata;
                rcms_pkg::CFG_SIMPLE_MASK: begin
                    cfg_reg.simple_mask <= cfg_wdata[rcms_pkg::PosCount-1:0];
                end
                rcms_pkg::CFG_SUPER_MASK: begin
                    cfg_reg.super_simple_mask <= cfg_wdata[rcms_pkg::PosCount-1:0];
                end
                rcms_pkg::CFG_AUX_SIMPLE:      cfg_reg.aux_simple_assigned <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{action: s_action, pulse_width: s_pulse_width,
                          radio_valid: s_radio_valid, mode_accepted: s_mode_accepted};
        end
    end

    rcms_switch_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_position       = result_reg.position;
    assign m_mode_request   = result_reg.mode_request;
    assign m_mode_number    = result_reg.mode_number;
    assign m_simple_update  = result_reg.simple_update;
    assign m_simple_setting = result_reg.simple_setting;

endmodule

// ===== rtl/core/rcms_checker.sv =====
// Port-level checks on the RC mode switch decoder, bound to the top level.
// Depends on rcms_pkg and rc_mode_switch_decoder.
`timescale 1ns / 1ps

module rcms_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rcms_pkg::PosWidth-1:0]  m_position,
    input logic                          m_mode_request,
    input logic [rcms_pkg::ModeWidth-1:0] m_mode_number,
    input logic                          m_simple_update,
    input logic [1:0]                    m_simple_setting
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    a_hold_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable({m_position, m_mode_request, m_mode_number,
                                         m_simple_update, m_simple_setting}))
        else $error("result item changed while stalled");

    a_mode_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_mode_request |-> m_mode_number == '0 && !m_simple_update)
        else $error("mode number or simple update without a request");

    a_setting: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_simple_update || m_simple_setting == rcms_pkg::SIMPLE_NONE)
                    && m_simple_setting != 2'd3)
        else $error("bad simple setting");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_position == rcms_pkg::PosOutOfRange |-> !m_mode_request)
        else $error("request on out-of-range pulse");

endmodule

bind rc_mode_switch_decoder rcms_checker u_rcms_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_position       (m_position),
    .m_mode_request   (m_mode_request),
    .m_mode_number    (m_mode_number),
    .m_simple_update  (m_simple_update),
    .m_simple_setting (m_simple_setting)
);
